### rtl/ska_pkg.sv
// ----------------------------------------------------------------------------
// ska_pkg
// shared constants, command codes, fsm states and result type for the
// skyline atlas allocator
// ----------------------------------------------------------------------------
package ska_pkg;

	localparam int PAGES_DEF       = 256;
	localparam int PAGE_WIDTH_DEF  = 128;
	localparam int PAGE_HEIGHT_DEF = 128;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [7:0] {
		ST_CLR  = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_PAGE = 8'b0000_0100,
		ST_RD   = 8'b0000_1000,
		ST_EV   = 8'b0001_0000,
		ST_DEC  = 8'b0010_0000,
		ST_WR   = 8'b0100_0000,
		ST_OUT  = 8'b1000_0000
	} state_t;

	typedef struct packed {
		logic [7:0] page_index;
		logic [6:0] pos_x;
		logic [6:0] pos_y;
		logic       full_res;
	} res_t;

endpackage

### rtl/ska_ram.sv
// ----------------------------------------------------------------------------
// ska_ram
// generic single port ram, synchronous write, registered read
// ----------------------------------------------------------------------------
module ska_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wr_data,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[addr] <= wr_data;
		end
		rd_data <= mem[addr];
	end

endmodule

### rtl/skyline_atlas_allocator.sv
// ----------------------------------------------------------------------------
// skyline_atlas_allocator
// places rectangles into texture pages using a per-column height skyline
// ----------------------------------------------------------------------------
// clear: sweeps the height ram to zero, then returns an all-zero result
// allocate: per page visited, windows of rect_w columns are read column by
// column, at most (PAGE_WIDTH-rect_w)*rect_w reads, then rect_w columns are
// written and the result goes out; one transaction in flight, and the next is
// taken while a result waits; reset: the height ram is swept to zero, stall high
module skyline_atlas_allocator #(
	parameter int PAGES       = ska_pkg::PAGES_DEF,
	parameter int PAGE_WIDTH  = ska_pkg::PAGE_WIDTH_DEF,
	parameter int PAGE_HEIGHT = ska_pkg::PAGE_HEIGHT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_stall,
	input  logic       command,
	input  logic [7:0] rect_w,
	input  logic [7:0] rect_h,
	output logic       res_valid,
	input  logic       res_stall,
	output logic [7:0] page_index,
	output logic [6:0] pos_x,
	output logic [6:0] pos_y,
	output logic       full_res
);

	localparam int PGW = $clog2(PAGES + 1);
	localparam int XW  = $clog2(PAGE_WIDTH) + 1;
	localparam int CI  = XW - 1;
	localparam int SW  = ((XW > 8) ? XW : 8) + 1;
	localparam int HW  = $clog2(PAGE_HEIGHT + 1);
	localparam int BW  = ((HW > 8) ? HW : 8) + 1;
	localparam int AW  = $clog2(PAGES * PAGE_WIDTH);

	ska_pkg::state_t state_q;
	ska_pkg::res_t   res_q, pend_q;

	logic [PGW-1:0] page_q, resume_q;
	logic [XW-1:0]  i_q, bx_q;
	logic [7:0]     j_q, w_q, h_q;
	logic [HW-1:0]  top_q, best_q;
	logic           found_q, clr_res_q, out_valid_q;
	logic [AW-1:0]  clr_q;

	logic [SW-1:0]  win_end, k_sum;
	logic [SW-1:0]  wr_sum;
	logic [BW-1:0]  new_top;
	logic [CI-1:0]  col;
	logic [AW-1:0]  mem_addr;
	logic           mem_we;
	logic [HW-1:0]  mem_wdata, mem_rdata;
	logic           res_load;

	assign win_end = SW'(i_q) + SW'(w_q);
	assign k_sum   = SW'(i_q) + SW'(j_q);
	assign wr_sum  = SW'(bx_q) + SW'(j_q);
	assign new_top = BW'(best_q) + BW'(h_q);
	assign col     = (state_q == ska_pkg::ST_WR) ? wr_sum[CI-1:0] : k_sum[CI-1:0];

	always_comb begin
		if (state_q == ska_pkg::ST_CLR) begin
			mem_addr = clr_q;
		end else begin
			mem_addr = AW'(page_q) * AW'(PAGE_WIDTH) + AW'(col);
		end
	end

	assign mem_we    = (state_q == ska_pkg::ST_CLR) ||
	                   ((state_q == ska_pkg::ST_WR) && (j_q != w_q));
	assign mem_wdata = (state_q == ska_pkg::ST_CLR) ? '0 : new_top[HW-1:0];

	ska_ram #(
		.WIDTH(HW),
		.DEPTH(PAGES * PAGE_WIDTH)
	) u_height_ram (
		.clk    (clk),
		.wr_en  (mem_we),
		.addr   (mem_addr),
		.wr_data(mem_wdata),
		.rd_data(mem_rdata)
	);

	assign cmd_stall = (state_q != ska_pkg::ST_IDLE);
	assign res_load  = (state_q == ska_pkg::ST_OUT) && (!out_valid_q || !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ska_pkg::ST_CLR;
			resume_q    <= '0;
			clr_q       <= '0;
			clr_res_q   <= 1'b0;
			out_valid_q <= 1'b0;
			page_q      <= '0;
			i_q         <= '0;
			j_q         <= '0;
			found_q     <= 1'b0;
			w_q         <= '0;
			h_q         <= '0;
			top_q       <= '0;
			best_q      <= '0;
			bx_q        <= '0;
			pend_q      <= '0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ska_pkg::ST_CLR: begin
					if (clr_q == AW'(PAGES * PAGE_WIDTH - 1)) begin
						clr_q    <= '0;
						resume_q <= '0;
						pend_q   <= '0;
						state_q  <= clr_res_q ? ska_pkg::ST_OUT : ska_pkg::ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ska_pkg::ST_IDLE: begin
					if (cmd_valid) begin
						w_q <= rect_w;
						h_q <= rect_h;
						page_q <= resume_q;
						if (command == ska_pkg::CMD_CLEAR) begin
							clr_res_q <= 1'b1;
							state_q   <= ska_pkg::ST_CLR;
						end else begin
							state_q <= ska_pkg::ST_PAGE;
						end
					end
				end
				ska_pkg::ST_PAGE: begin
					i_q     <= '0;
					j_q     <= '0;
					top_q   <= '0;
					best_q  <= HW'(PAGE_HEIGHT);
					bx_q    <= '0;
					found_q <= 1'b0;
					if (page_q == PGW'(PAGES) || SW'(w_q) >= SW'(PAGE_WIDTH)) begin
						resume_q <= PGW'(PAGES);
						pend_q   <= '{page_index: 8'd0, pos_x: 7'd0, pos_y: 7'd0,
						              full_res: 1'b1};
						state_q  <= ska_pkg::ST_OUT;
					end else begin
						state_q <= ska_pkg::ST_RD;
					end
				end
				ska_pkg::ST_RD: begin
					if (win_end >= SW'(PAGE_WIDTH)) begin
						state_q <= ska_pkg::ST_DEC;
					end else if (j_q == w_q) begin
						if (top_q < best_q) begin
							best_q  <= top_q;
							bx_q    <= i_q;
							found_q <= 1'b1;
						end
						i_q   <= i_q + 1'b1;
						j_q   <= '0;
						top_q <= '0;
					end else begin
						state_q <= ska_pkg::ST_EV;
					end
				end
				ska_pkg::ST_EV: begin
					if (mem_rdata >= best_q) begin
						i_q   <= XW'(k_sum + 1'b1);
						j_q   <= '0;
						top_q <= '0;
					end else begin
						if (mem_rdata > top_q) begin
							top_q <= mem_rdata;
						end
						j_q <= j_q + 1'b1;
					end
					state_q <= ska_pkg::ST_RD;
				end
				ska_pkg::ST_DEC: begin
					j_q <= '0;
					if (found_q && new_top <= BW'(PAGE_HEIGHT)) begin
						state_q <= ska_pkg::ST_WR;
					end else begin
						page_q  <= page_q + 1'b1;
						state_q <= ska_pkg::ST_PAGE;
					end
				end
				ska_pkg::ST_WR: begin
					if (j_q == w_q) begin
						resume_q <= page_q;
						pend_q   <= '{page_index: 8'(page_q), pos_x: 7'(bx_q),
						              pos_y: 7'(best_q), full_res: 1'b0};
						state_q  <= ska_pkg::ST_OUT;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				ska_pkg::ST_OUT: begin
					if (res_load) begin
						clr_res_q <= 1'b0;
						state_q   <= ska_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= ska_pkg::ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= pend_q;
		end
	end

	assign res_valid  = out_valid_q;
	assign page_index = res_q.page_index;
	assign pos_x      = res_q.pos_x;
	assign pos_y      = res_q.pos_y;
	assign full_res   = res_q.full_res;

	a_ev_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ska_pkg::ST_EV |-> $past(state_q) == ska_pkg::ST_RD)
		else $error("window read evaluated without a preceding read");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q == ska_pkg::ST_WR || state_q == ska_pkg::ST_CLR))
		else $error("height ram written outside write or clear");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ska_pkg::ST_OUT && out_valid_q && res_stall)
		|=> state_q == ska_pkg::ST_OUT)
		else $error("result dropped while output stalled");

	a_resume_range: assert property (@(posedge clk) disable iff (!arst_n)
		resume_q <= PGW'(PAGES))
		else $error("resume page out of range");

endmodule
